>>> sv/lis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lis_pkg
// Shared types for the longest increasing subsequence block: the width of
// the reported lengths and the result record passed to the output stage.
// ----------------------------------------------------------------------------
package lis_pkg;

    // Reported lengths are the low bits of the internal length.
    localparam int RES_LEN_W = 9;

    typedef struct packed {
        logic [RES_LEN_W-1:0] end_length;
        logic [RES_LEN_W-1:0] best_length;
        logic                 overflow;
    } lis_result_t;

endpackage

>>> sv/longest_increasing_subsequence_length.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_increasing_subsequence_length
// Streaming longest strictly increasing subsequence (quadratic DP).
//
// Input channel (s_*): one signed element per transfer; s_first starts a new
// sequence. Output channel (m_*): one result per element with the length of
// the run ending at it, the best so far and a sticky overflow flag.
// Per element the scan reads each stored entry once from a single-port-read
// store, n being the number of stored entries (at most MAX_LEN). s_ready
// returns when the result is handed on, and m_valid rises as the output
// register takes that result.
// Only one element is in flight; the next may be taken while the previous
// result still sits in the output register. If the receiver stalls, the
// finished element waits in the scan unit and the store is not updated
// until its result moves on.
// Reset (synchronous, aresetn low) empties the sequence; the store itself
// is not cleared, as only entries written in the current sequence are read.
// Elements beyond MAX_LEN are scored but not stored and set overflow.
// ----------------------------------------------------------------------------
module longest_increasing_subsequence_length #(
    parameter int MAX_LEN    = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [DATA_WIDTH-1:0]         s_elem_value,
    input  logic                          s_first,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lis_pkg::RES_LEN_W-1:0] m_end_length,
    output logic [lis_pkg::RES_LEN_W-1:0] m_best_length,
    output logic                          m_overflow
);
    import lis_pkg::*;

    logic        res_valid;
    logic        res_ready;
    lis_result_t res;

    // output register
    logic        m_valid_reg, m_valid_next;
    lis_result_t out_reg;

    lis_scan #(
        .MAX_LEN    (MAX_LEN),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_value  (s_elem_value),
        .in_first  (s_first),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // free when empty or being drained this cycle
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_end_length  = out_reg.end_length;
    assign m_best_length = out_reg.best_length;
    assign m_overflow    = out_reg.overflow;

endmodule

>>> sv/lis_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lis_scan
// Element store and scan sequencer. Holds the keys and lengths of the
// current sequence in one synchronous memory, scans every stored entry for
// each new element and, if there is room, stores it once its result is taken.
// ----------------------------------------------------------------------------
module lis_scan #(
    parameter int MAX_LEN    = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DATA_WIDTH-1:0] in_value,
    input  logic                  in_first,
    output logic                  res_valid,
    input  logic                  res_ready,
    output lis_pkg::lis_result_t  res
);
    import lis_pkg::*;

    localparam int AW    = $clog2(MAX_LEN);
    localparam int LW    = $clog2(MAX_LEN + 1);
    localparam int WORDW = DATA_WIDTH + LW;

    localparam logic [DATA_WIDTH-1:0] SIGN_FLIP = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [LW-1:0]         FULL      = LW'(MAX_LEN);
    localparam logic [LW:0]           LIMIT     = (LW+1)'(MAX_LEN);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    // control
    logic [1:0]            state_reg, state_next;
    logic [LW-1:0]         count_reg, count_next;
    logic [LW-1:0]         best_reg,  best_next;
    logic                  ovf_reg,   ovf_next;
    logic                  rvalid_reg, rvalid_next;
    // payload
    logic [DATA_WIDTH-1:0] key_reg, key_next;
    logic [LW-1:0]         len_reg, len_next;
    logic [LW-1:0]         idx_reg, idx_next;

    // element store
    logic [WORDW-1:0]      mem [MAX_LEN];
    logic [WORDW-1:0]      rd_data_reg;
    logic                  mem_we, mem_re;

    logic [DATA_WIDTH-1:0] rd_key;
    logic [LW-1:0]         rd_len;
    logic [LW:0]           cand;
    logic [LW-1:0]         cand_sat;
    logic [LW-1:0]         best_new;
    logic                  ovf_new;
    logic [LW+RES_LEN_W-1:0] len_wide, best_wide;

    assign rd_key   = rd_data_reg[WORDW-1:LW];
    assign rd_len   = rd_data_reg[LW-1:0];
    assign cand     = {1'b0, rd_len} + (LW+1)'(1);
    assign cand_sat = (cand > LIMIT) ? FULL : cand[LW-1:0];

    assign best_new = (len_reg > best_reg) ? len_reg : best_reg;
    assign ovf_new  = ovf_reg | (count_reg == FULL);

    assign len_wide  = {{RES_LEN_W{1'b0}}, len_reg};
    assign best_wide = {{RES_LEN_W{1'b0}}, best_new};

    assign in_ready         = (state_reg == ST_IDLE);
    assign res.end_length   = len_wide[RES_LEN_W-1:0];
    assign res.best_length  = best_wide[RES_LEN_W-1:0];
    assign res.overflow     = ovf_new;

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        best_next   = best_reg;
        ovf_next    = ovf_reg;
        rvalid_next = 1'b0;
        key_next    = key_reg;
        len_next    = len_reg;
        idx_next    = idx_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        res_valid   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    key_next   = in_value ^ SIGN_FLIP;
                    len_next   = LW'(1);
                    idx_next   = '0;
                    state_next = ST_SCAN;
                    if (in_first) begin
                        count_next = '0;
                        best_next  = '0;
                        ovf_next   = 1'b0;
                    end
                end
            end
            ST_SCAN: begin
                // data read last cycle is folded in here
                if (rvalid_reg && (rd_key < key_reg) && (cand > {1'b0, len_reg})) begin
                    len_next = cand_sat;
                end
                if (idx_reg != count_reg) begin
                    mem_re      = 1'b1;
                    idx_next    = idx_reg + LW'(1);
                    rvalid_next = 1'b1;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                res_valid = 1'b1;
                // state and store only change on the handoff cycle
                if (res_ready) begin
                    state_next = ST_IDLE;
                    best_next  = best_new;
                    ovf_next   = ovf_new;
                    if (count_reg != FULL) begin
                        mem_we     = 1'b1;
                        count_next = count_reg + LW'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            best_reg   <= '0;
            ovf_reg    <= 1'b0;
            rvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            best_reg   <= best_next;
            ovf_reg    <= ovf_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        len_reg <= len_next;
        idx_reg <= idx_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[count_reg[AW-1:0]] <= {key_reg, len_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_data_reg <= mem[idx_reg[AW-1:0]];
        end
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for longest_increasing_subsequence_length. A short
// table of directed elements covers sign extremes, equal values, a missing
// first flag after reset and sequence restarts. Random sequences follow,
// including two that run past the store depth so that saturation and the
// sticky overflow flag are reached. A local scoring model predicts each result
// not fixed by hand. Both channels stall at random in changing proportions.
// ----------------------------------------------------------------------------
module testbench;

    import lis_pkg::*;

    localparam int ELEM_W       = 32;
    localparam int STORE_DEPTH  = 256;
    localparam int RAND_ITEMS   = 1350;
    // The drain outlasts the scan of one element against a full store.
    localparam int DRAIN_CYCLES = STORE_DEPTH + 40;
    localparam int STALL_LIMIT  = 5000;

    typedef enum int {
        VAL_FULL,
        VAL_NARROW,
        VAL_CORNER,
        VAL_RISING,
        VAL_FALLING
    } value_mode_t;

    // One input element; fixed rows carry a hand-written result.
    typedef struct packed {
        logic [ELEM_W-1:0] value;
        logic              first;
        logic              fixed;
        lis_result_t       want;
    } lis_row_t;

    localparam int DIRECTED_ROWS = 24;

    // Rows with fixed = 0 are scored by the model below.
    lis_row_t directed_rows [DIRECTED_ROWS] = '{
        '{32'h0000_0000, 1'b0, 1'b1, '{9'd1, 9'd1, 1'b0}}, // no first after reset
        '{32'h7FFF_FFFF, 1'b0, 1'b0, '0},
        '{32'h8000_0000, 1'b0, 1'b1, '{9'd1, 9'd2, 1'b0}}, // minimum never extends
        '{32'h8000_0000, 1'b0, 1'b1, '{9'd1, 9'd2, 1'b0}}, // equal does not extend
        '{32'h8000_0000, 1'b1, 1'b1, '{9'd1, 9'd1, 1'b0}}, // restart clears best
        '{32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{32'h0000_0000, 1'b0, 1'b0, '0},
        '{32'h0000_0001, 1'b0, 1'b0, '0},
        '{32'h0000_0000, 1'b0, 1'b0, '0},
        '{32'h7FFF_FFFF, 1'b0, 1'b0, '0},
        '{32'h7FFF_FFFE, 1'b0, 1'b0, '0},
        '{32'h7FFF_FFFF, 1'b1, 1'b1, '{9'd1, 9'd1, 1'b0}},
        '{32'h7FFF_FFFF, 1'b0, 1'b1, '{9'd1, 9'd1, 1'b0}}, // repeated maximum
        '{32'hFFFF_FFFE, 1'b0, 1'b0, '0},
        '{32'h0000_0005, 1'b0, 1'b0, '0},
        '{32'h0000_0005, 1'b0, 1'b0, '0},
        '{32'h0000_0006, 1'b0, 1'b0, '0},
        '{32'h5555_5555, 1'b1, 1'b1, '{9'd1, 9'd1, 1'b0}},
        '{32'hAAAA_AAAA, 1'b0, 1'b0, '0},
        '{32'h1234_5678, 1'b0, 1'b0, '0},
        '{32'hEDCB_A987, 1'b0, 1'b0, '0},
        '{32'h8000_0001, 1'b0, 1'b0, '0},
        '{32'h8000_0000, 1'b1, 1'b1, '{9'd1, 9'd1, 1'b0}},
        '{32'h7FFF_FFFF, 1'b0, 1'b1, '{9'd2, 9'd2, 1'b0}}  // minimum then maximum
    };

    localparam logic [ELEM_W-1:0] CORNER_VALUES [7] = '{
        32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF, 32'h0000_0000,
        32'h0000_0001, 32'h7FFF_FFFE, 32'h7FFF_FFFF
    };

    logic              aclk;
    logic              aresetn      = 1'b0;
    logic              s_valid      = 1'b0;
    logic              s_ready;
    logic [ELEM_W-1:0] s_elem_value = '0;
    logic              s_first      = 1'b0;
    logic              m_valid;
    logic              m_ready      = 1'b0;
    logic [RES_LEN_W-1:0] m_end_length;
    logic [RES_LEN_W-1:0] m_best_length;
    logic              m_overflow;

    lis_row_t    stim_items [$];
    lis_result_t pending_results [$];
    int          items_sent  = 0;
    int          phase_len   = 1;
    int          error_count = 0;
    int          send_idle_pct;
    int          recv_idle_pct;

    // Scoring model state: the current sequence as stored by the block.
    logic signed [ELEM_W-1:0] seq_values  [STORE_DEPTH];
    int                       seq_lengths [STORE_DEPTH];
    int                       seq_count   = 0;
    int                       seq_best    = 0;
    logic                     seq_overflow = 1'b0;

    longest_increasing_subsequence_length #(
        .MAX_LEN    (STORE_DEPTH),
        .DATA_WIDTH (ELEM_W)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_elem_value  (s_elem_value),
        .s_first       (s_first),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_end_length  (m_end_length),
        .m_best_length (m_best_length),
        .m_overflow    (m_overflow)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Scores one element against the stored sequence and updates it.
    // An element beyond the store depth is scored but not kept, and the
    // overflow flag sticks until the next first flag.
    function automatic lis_result_t score_element(input logic signed [ELEM_W-1:0] value,
                                                  input logic first);
        int          run_len;
        int          i;
        lis_result_t res;
        if (first) begin
            seq_count    = 0;
            seq_best     = 0;
            seq_overflow = 1'b0;
        end
        run_len = 1;
        for (i = 0; i < seq_count; i++) begin
            // strictly smaller only: equal values never extend a run
            if (seq_values[i] < value && seq_lengths[i] + 1 > run_len) begin
                run_len = seq_lengths[i] + 1;
            end
        end
        if (run_len > STORE_DEPTH) begin
            run_len = STORE_DEPTH;
        end
        if (seq_count < STORE_DEPTH) begin
            seq_values[seq_count]  = value;
            seq_lengths[seq_count] = run_len;
            seq_count++;
        end else begin
            seq_overflow = 1'b1;
        end
        if (run_len > seq_best) begin
            seq_best = run_len;
        end
        res.end_length  = run_len[RES_LEN_W-1:0];
        res.best_length = seq_best[RES_LEN_W-1:0];
        res.overflow    = seq_overflow;
        return res;
    endfunction

    task automatic check_field(input string field, input logic [RES_LEN_W-1:0] want,
                               input logic [RES_LEN_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            error_count++;
        end
    endtask

    // Idle mix per phase of the run, stepped by input transfers: sender
    // light and receiver heavy, then swapped, then no idling at all.
    always_comb begin
        if (items_sent < phase_len) begin
            send_idle_pct = 38;
            recv_idle_pct = 79;
        end else if (items_sent < 2 * phase_len) begin
            send_idle_pct = 79;
            recv_idle_pct = 38;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    // Sender: scores each element at its transfer and queues the result
    // expected for it, then offers the next element or idles.
    always @(posedge aclk) begin
        int          next_idx;
        lis_result_t predicted;
        next_idx = items_sent;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predicted = score_element(stim_items[next_idx].value,
                                          stim_items[next_idx].first);
                // the model still runs on fixed rows to keep its state
                pending_results.push_back(stim_items[next_idx].fixed ?
                                          stim_items[next_idx].want : predicted);
                next_idx++;
            end
            if (!s_valid || s_ready) begin
                if (next_idx < stim_items.size() && $urandom_range(99, 0) >= send_idle_pct) begin
                    s_valid      <= 1'b1;
                    s_elem_value <= stim_items[next_idx].value;
                    s_first      <= stim_items[next_idx].first;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
        items_sent <= next_idx;
    end

    // Receiver: checks each result transfer against the oldest expectation.
    always @(posedge aclk) begin
        lis_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %0d/%0d/%0d",
                         $time, m_end_length, m_best_length, m_overflow);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("end_length", want.end_length, m_end_length);
                check_field("best_length", want.best_length, m_best_length);
                check_field("overflow", {8'd0, want.overflow}, {8'd0, m_overflow});
            end
        end
        m_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // Ends the run if neither channel has moved a transfer for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("FAIL");
        $finish;
    end

    initial begin : main_seq
        int           seq_idx;
        int           seq_len;
        int           rand_count;
        int           k;
        bit           long_seq;
        bit           start_new;
        value_mode_t  mode;
        logic [ELEM_W-1:0] level;
        lis_row_t     row;

        foreach (directed_rows[r]) begin
            stim_items.push_back(directed_rows[r]);
        end

        // Random sequences. Most are short; sequences three and forty run
        // past the store depth, one strictly rising to hit saturation, the
        // other in a narrow range. About one in eight short sequences
        // carries on from the last one without a first flag.
        seq_idx    = 0;
        rand_count = 0;
        row        = '0;
        while (rand_count < RAND_ITEMS) begin
            long_seq = (seq_idx == 3) || (seq_idx == 40);
            if (seq_idx == 3) begin
                seq_len = $urandom_range(270, 260);
                mode    = VAL_RISING;
            end else if (seq_idx == 40) begin
                seq_len = $urandom_range(266, 257);
                mode    = VAL_NARROW;
            end else begin
                seq_len = $urandom_range(24, 1);
                mode    = value_mode_t'($urandom_range(4, 0));
            end
            start_new = long_seq || ($urandom_range(7, 0) != 0);
            level = (mode == VAL_RISING) ? 32'h8000_0000 + $urandom_range(4096, 0)
                                         : 32'h7FFF_FFFF - $urandom_range(4096, 0);
            for (k = 0; k < seq_len; k++) begin
                case (mode)
                    VAL_FULL: begin
                        row.value = $urandom;
                    end
                    VAL_NARROW: begin
                        row.value = ELEM_W'($urandom_range(16, 0)) - 32'd8;
                    end
                    VAL_CORNER: begin
                        row.value = CORNER_VALUES[$urandom_range(6, 0)];
                    end
                    VAL_RISING: begin
                        // short runs may repeat a value, the long one may not
                        level     = level + $urandom_range(1 << 16, long_seq ? 1 : 0);
                        row.value = level;
                    end
                    default: begin
                        level     = level - $urandom_range(1 << 16, 0);
                        row.value = level;
                    end
                endcase
                // occasional stray value in a short sequence
                if (!long_seq && $urandom_range(5, 0) == 0) begin
                    row.value = $urandom;
                end
                row.first = (k == 0) ? start_new
                                     : (!long_seq && $urandom_range(63, 0) == 0);
                stim_items.push_back(row);
                rand_count++;
            end
            seq_idx++;
        end
        phase_len = stim_items.size() / 3;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (items_sent < stim_items.size()) @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        // any stray result after the last one is flagged by the receiver
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/lis_pkg.sv
sv/lis_scan.sv
sv/longest_increasing_subsequence_length.sv
sim/testbench.sv
